// ----- hw/rtl/polyline_even_spacing_resampler_assert.svh -----
`ifndef POLYLINE_EVEN_SPACING_RESAMPLER_ASSERT_SVH
`define POLYLINE_EVEN_SPACING_RESAMPLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PESR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Next-cycle implication.
`define PESR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

// ----- hw/rtl/pesr_pkg.sv -----
package pesr_pkg;

  localparam logic [23:0] SPACING_MIN   = 24'd1280;
  localparam logic [23:0] SPACING_RESET = 24'd6400;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               path_start;
  } pesr_in_t;

  typedef struct packed {
    logic signed [31:0] dot_x;
    logic signed [31:0] dot_y;
    logic signed [31:0] dot_z;
    logic               last_dot;
    logic               overflow;
  } pesr_out_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } iter_op_t;

  typedef struct packed {
    logic       start;
    iter_op_t   op;
    logic [5:0] steps;
  } iter_cmd_t;

endpackage

// ----- hw/rtl/pesr_in_if.sv -----
interface pesr_in_if;
  import pesr_pkg::*;

  logic     valid;
  logic     ready;
  pesr_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/pesr_out_if.sv -----
interface pesr_out_if;
  import pesr_pkg::*;

  logic      valid;
  logic      ready;
  pesr_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/polyline_even_spacing_resampler.sv -----
// Channel   Direction  Payload
// in_ch     sink       point_x, point_y, point_z, path_start
// out_ch    source     dot_x, dot_y, dot_z, last_dot, overflow
// cfg_      write      dot_spacing (24 bit, no read-back)
//
// A path-start vertex only restarts the path. A segment is worked in one
// shift-add/subtract unit (three squares, a square root, a remainder, three
// divisions and six multiplies), then emits its points, one per cycle unless stalled.
// Reset is synchronous and active low; it restores the spacing to 25.0.
// A stalled output holds its point; no new vertex is taken until the last
// point of the current one is in the output register.
module polyline_even_spacing_resampler #(
  parameter int MAX_DOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pesr_in_if.sink     in_ch,
  pesr_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  import pesr_pkg::*;

  `include "polyline_even_spacing_resampler_assert.svh"

  localparam int KW = $clog2(MAX_DOTS + 1);
  localparam logic signed [35:0] PMAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] PMIN = 36'shF80000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_CHK, ST_MOD, ST_DIV, ST_MC, ST_MS, ST_EMIT
  } state_t;

  state_t             state_r;
  logic               go_r;
  logic [1:0]         ax_r;
  logic [23:0]        sp_r;
  logic               have_r;
  logic [23:0]        carry_r;
  logic [23:0]        c0_r;
  logic signed [31:0] prev_r [3];
  logic signed [31:0] from_r [3];
  logic [31:0]        mag_r  [3];
  logic               neg_r  [3];
  logic [30:0]        dir_r  [3];
  logic [63:0]        pos_r  [3];
  logic [53:0]        inc_r  [3];
  logic [32:0]        len_r;
  logic               ovf_r;
  logic [33:0]        along_r;
  logic [KW-1:0]      k_r;
  logic               out_valid_r;
  pesr_out_t          out_data_r;

  iter_cmd_t          cmd;
  logic [65:0]        init_acc;
  logic [63:0]        init_a;
  logic [32:0]        init_b, init_d;
  logic               it_busy;
  logic [65:0]        it_acc;
  logic [63:0]        it_a;
  logic [32:0]        it_b;

  logic               in_fire, emit_fire, op_done, last;
  logic signed [31:0] in_pt  [3];
  logic [32:0]        in_diff[3];
  logic [32:0]        span;
  logic [33:0]        ovf_lim;
  logic [33:0]        along_nxt;
  logic [31:0]        pt_out [3];
  logic signed [35:0] psum   [3];
  logic [33:0]        off    [3];

  pesr_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .init_acc (init_acc),
    .init_a   (init_a),
    .init_b   (init_b),
    .init_d   (init_d),
    .busy     (it_busy),
    .acc      (it_acc),
    .opa      (it_a),
    .opb      (it_b)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign emit_fire    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign op_done      = go_r && !it_busy;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign in_pt[0] = in_ch.data.point_x;
  assign in_pt[1] = in_ch.data.point_y;
  assign in_pt[2] = in_ch.data.point_z;

  assign span      = len_r - {9'd0, c0_r};
  assign ovf_lim   = {10'd0, carry_r} + 34'(MAX_DOTS) * {10'd0, sp_r};
  assign along_nxt = along_r + {10'd0, sp_r};
  assign last      = (along_nxt >= {1'b0, len_r}) || (k_r == KW'(MAX_DOTS - 1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_diff[i] = {in_pt[i][31], in_pt[i]} - {prev_r[i][31], prev_r[i]};
      off[i]     = pos_r[i][63:30];
      if (neg_r[i]) begin
        psum[i] = {{4{from_r[i][31]}}, from_r[i]} - $signed({2'b00, off[i]});
      end else begin
        psum[i] = {{4{from_r[i][31]}}, from_r[i]} + $signed({2'b00, off[i]});
      end
      if (psum[i] > PMAX) begin
        pt_out[i] = PMAX[31:0];
      end else if (psum[i] < PMIN) begin
        pt_out[i] = PMIN[31:0];
      end else begin
        pt_out[i] = psum[i][31:0];
      end
    end
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    cmd.steps = 6'd32;
    init_acc  = '0;
    init_a    = '0;
    init_b    = '0;
    init_d    = '0;
    unique case (state_r)
      ST_SQ: begin
        cmd.start = !go_r;
        init_acc  = (ax_r == 2'd0) ? 66'd0 : it_acc;
        init_a    = {32'd0, mag_r[ax_r]};
        init_b    = {1'b0, mag_r[ax_r]};
      end
      ST_SQRT: begin
        cmd.start = !go_r;
        cmd.op    = OP_SQRT;
        cmd.steps = 6'd33;
        init_acc  = it_acc;
      end
      ST_MOD: begin
        cmd.start = !go_r;
        cmd.op    = OP_DIV;
        cmd.steps = 6'd33;
        init_acc  = {span, 33'd0};
        init_d    = {9'd0, sp_r};
      end
      ST_DIV: begin
        cmd.start = !go_r;
        cmd.op    = OP_DIV;
        cmd.steps = 6'd31;
        init_acc  = {mag_r[ax_r][0], 65'd0};
        init_a    = {33'd0, mag_r[ax_r][31:1]};
        init_d    = len_r;
      end
      ST_MC: begin
        cmd.start = !go_r;
        cmd.steps = 6'd24;
        init_a    = {33'd0, dir_r[ax_r]};
        init_b    = {9'd0, c0_r};
      end
      ST_MS: begin
        cmd.start = !go_r;
        cmd.steps = 6'd24;
        init_a    = {33'd0, dir_r[ax_r]};
        init_b    = {9'd0, sp_r};
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      ax_r        <= '0;
      sp_r        <= SPACING_RESET;
      have_r      <= 1'b0;
      carry_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      if (cmd.start) begin
        go_r <= 1'b1;
      end else if (op_done) begin
        go_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        sp_r <= (cfg_wr_data < SPACING_MIN) ? SPACING_MIN : cfg_wr_data;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
              prev_r[i] <= in_pt[i];
            end
            if (in_ch.data.path_start || !have_r) begin
              carry_r <= '0;
              have_r  <= 1'b1;
            end else begin
              ax_r    <= 2'd0;
              state_r <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          if (op_done) begin
            if (ax_r == 2'd2) begin
              state_r <= ST_SQRT;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        ST_SQRT: begin
          if (op_done) begin
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (len_r == 33'd0) begin
            state_r <= ST_IDLE;
          end else if ({9'd0, carry_r} >= len_r) begin
            carry_r <= carry_r - len_r[23:0];
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (op_done) begin
            carry_r <= (it_a[23:0] != 24'd0) ? sp_r - it_a[23:0] : 24'd0;
            ax_r    <= 2'd0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (op_done) begin
            state_r <= ST_MC;
          end
        end
        ST_MC: begin
          if (op_done) begin
            state_r <= ST_MS;
          end
        end
        ST_MS: begin
          if (op_done) begin
            if (ax_r == 2'd2) begin
              k_r     <= '0;
              state_r <= ST_EMIT;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= ST_DIV;
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            k_r <= k_r + KW'(1);
            if (last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        from_r[i] <= prev_r[i];
        neg_r[i]  <= in_diff[i][32];
        mag_r[i]  <= in_diff[i][32] ? 32'(-in_diff[i]) : in_diff[i][31:0];
      end
    end
    if (state_r == ST_SQRT && op_done) begin
      len_r <= it_b;
    end
    if (state_r == ST_CHK) begin
      c0_r    <= carry_r;
      along_r <= {10'd0, carry_r};
      ovf_r   <= ovf_lim < {1'b0, len_r};
    end
    if (state_r == ST_DIV && op_done) begin
      dir_r[ax_r] <= it_b[30:0];
    end
    if (state_r == ST_MC && op_done) begin
      pos_r[ax_r] <= it_acc[63:0] + 64'h0000_0000_2000_0000;
    end
    if (state_r == ST_MS && op_done) begin
      inc_r[ax_r] <= it_acc[53:0];
    end
    if (emit_fire) begin
      out_data_r.dot_x    <= pt_out[0];
      out_data_r.dot_y    <= pt_out[1];
      out_data_r.dot_z    <= pt_out[2];
      out_data_r.last_dot <= last;
      out_data_r.overflow <= ovf_r;
      along_r             <= along_nxt;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_r[i] + {10'd0, inc_r[i]};
      end
    end
  end

  `PESR_ASSERT_NOW(a_spacing_floor, 1'b1, sp_r >= SPACING_MIN)
  `PESR_ASSERT_NEXT(a_start_no_work, in_fire && (in_ch.data.path_start || !have_r), state_r == ST_IDLE)
  `PESR_ASSERT_NEXT(a_last_ends, emit_fire && last, state_r == ST_IDLE)
  `PESR_ASSERT_NOW(a_dot_bound, state_r == ST_EMIT, k_r < KW'(MAX_DOTS))
endmodule

// ----- hw/rtl/pesr_iter.sv -----
module pesr_iter (
  input  logic                clk,
  input  logic                rst_n,
  input  pesr_pkg::iter_cmd_t cmd,
  input  logic [65:0]         init_acc,
  input  logic [63:0]         init_a,
  input  logic [32:0]         init_b,
  input  logic [32:0]         init_d,
  output logic                busy,
  output logic [65:0]         acc,
  output logic [63:0]         opa,
  output logic [32:0]         opb
);
  import pesr_pkg::*;

  // One shared subtractor serves the square root and the division steps.
  // The multiply steps are shift-and-add on the accumulator.
  iter_op_t    op_r;
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [65:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt;
  logic [32:0] b_r, b_nxt;
  logic [32:0] d_r;
  logic [35:0] sub_a, sub_b, sub_res;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    if (op_r == OP_SQRT) begin
      sub_a = {a_r[33:0], acc_r[65:64]};
      sub_b = {1'b0, b_r, 2'b01};
    end else begin
      sub_a = {2'b00, a_r[32:0], acc_r[65]};
      sub_b = {3'b000, d_r};
    end
    diff    = {1'b0, sub_a} - {1'b0, sub_b};
    ge      = ~diff[36];
    sub_res = ge ? diff[35:0] : sub_a;
    unique case (op_r)
      OP_MUL: begin
        acc_nxt = acc_r + (b_r[0] ? {2'b00, a_r} : 66'd0);
        a_nxt   = a_r << 1;
        b_nxt   = b_r >> 1;
      end
      OP_SQRT: begin
        acc_nxt = acc_r << 2;
        a_nxt   = {30'd0, sub_res[33:0]};
        b_nxt   = {b_r[31:0], ge};
      end
      OP_DIV: begin
        acc_nxt = acc_r << 1;
        a_nxt   = {31'd0, sub_res[32:0]};
        b_nxt   = {b_r[31:0], ge};
      end
      default: begin
        acc_nxt = acc_r;
        a_nxt   = a_r;
        b_nxt   = b_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.steps;
      op_r   <= cmd.op;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= init_acc;
      a_r   <= init_a;
      b_r   <= init_b;
      d_r   <= init_d;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
    end
  end

  assign busy = busy_r;
  assign acc  = acc_r;
  assign opa  = a_r;
  assign opb  = b_r;
endmodule

// ----- dv/polyline_even_spacing_resampler_test.sv -----
`timescale 1ns / 100ps

module polyline_even_spacing_resampler_test;
  import pesr_pkg::*;

  localparam int SEGMENT_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 500;
  localparam int CHUNKS = 6;
  localparam int CHUNK_POINTS = 80;

  typedef struct {
    bit          write_cfg;
    logic [23:0] cfg_value;
    pesr_in_t    vertex;
    bit          typed;
    pesr_out_t   dot;
  } vertex_row_t;

  typedef struct {
    bit        typed;
    pesr_out_t dot;
  } vertex_claim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;

  pesr_in_if in_if();
  pesr_out_if out_if();

  polyline_even_spacing_resampler uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [23:0] spacing_q8;
  logic signed [31:0] last_x, last_y, last_z;
  logic [31:0] carry_q8;
  bit have_vertex;

  pesr_out_t expected_dots[$];
  pesr_out_t vertex_dots[$];
  vertex_claim_t vertex_claims[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] magnitude(input logic signed [63:0] d);
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [31:0] place_axis(input logic signed [63:0] from,
      input logic signed [63:0] d, input logic [63:0] along, input logic [63:0] len);
    logic [63:0] dir, off;
    logic signed [63:0] p;
    dir = (magnitude(d) << 30) / len;
    off = (dir * along + 64'd536870912) >> 30;
    p = d < 0 ? from - $signed(off) : from + $signed(off);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic void predict_dots(input pesr_in_t v);
    logic signed [31:0] xs, ys, zs;
    logic signed [63:0] fx, fy, fz, dx, dy, dz;
    logic [67:0] sumsq, t, mx, my, mz;
    logic [63:0] len, c0, sp, span, n, r, emit, along;
    pesr_out_t d;
    vertex_dots.delete();
    xs = v.point_x;
    ys = v.point_y;
    zs = v.point_z;
    fx = last_x;
    fy = last_y;
    fz = last_z;
    if (v.path_start || !have_vertex) begin
      last_x = xs;
      last_y = ys;
      last_z = zs;
      carry_q8 = '0;
      have_vertex = 1'b1;
      return;
    end
    dx = xs - fx;
    dy = ys - fy;
    dz = zs - fz;
    mx = magnitude(dx);
    my = magnitude(dy);
    mz = magnitude(dz);
    sumsq = mx * mx + my * my + mz * mz;
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      t = 68'(len | (64'd1 << b));
      if (t * t <= sumsq) len = t[63:0];
    end
    last_x = xs;
    last_y = ys;
    last_z = zs;
    if (len == 0) return;
    c0 = carry_q8;
    if (c0 >= len) begin
      carry_q8 = 32'(c0 - len);
      return;
    end
    sp = spacing_q8;
    span = len - c0;
    n = (span + sp - 1) / sp;
    r = span % sp;
    carry_q8 = r != 0 ? 32'(sp - r) : 32'd0;
    emit = n > 64 ? 64 : n;
    for (int k = 0; k < emit; k++) begin
      along = c0 + k * sp;
      d.dot_x = place_axis(fx, dx, along, len);
      d.dot_y = place_axis(fy, dy, along, len);
      d.dot_z = place_axis(fz, dz, along, len);
      d.last_dot = (k + 1 == emit);
      d.overflow = (n > 64);
      vertex_dots.push_back(d);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_claim_t c;
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_dots(in_if.data);
      c = vertex_claims.pop_front();
      if (c.typed) expected_dots.push_back(c.dot);
      else foreach (vertex_dots[i]) expected_dots.push_back(vertex_dots[i]);
    end
  end

  always @(posedge clk) begin
    pesr_out_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_dots.size() == 0) begin
        report_mismatch("unexpected transaction, dot_x", got.dot_x, '0);
      end else begin
        want = expected_dots.pop_front();
        if (got.dot_x !== want.dot_x) report_mismatch("dot_x", got.dot_x, want.dot_x);
        if (got.dot_y !== want.dot_y) report_mismatch("dot_y", got.dot_y, want.dot_y);
        if (got.dot_z !== want.dot_z) report_mismatch("dot_z", got.dot_z, want.dot_z);
        if (got.last_dot !== want.last_dot)
          report_mismatch("last_dot", got.last_dot, want.last_dot);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic offer_vertex(input pesr_in_t v, input bit typed, input pesr_out_t dot);
    vertex_claim_t c;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    c.typed = typed;
    c.dot = dot;
    vertex_claims.push_back(c);
    in_if.valid <= 1'b1;
    in_if.data <= v;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain_dots();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_dots.size() > 0) @(posedge clk);
    repeat (SEGMENT_CYCLES) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [23:0] value);
    drain_dots();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    spacing_q8 = value < SPACING_MIN ? SPACING_MIN : value;
  endtask

  function automatic logic [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] random_step(input int scale);
    logic signed [63:0] m;
    m = $urandom_range(0, scale);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  vertex_row_t rows[] = '{
    '{0, 24'd0, '{32'sd0, 32'sd0, 32'sd0, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'sd6400, 32'sd0, 32'sd0, 1'b0}, 1, '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0}},
    '{0, 24'd0, '{32'sd12800, 32'sd0, 32'sd0, 1'b0}, 1,
      '{32'sd6400, 32'sd0, 32'sd0, 1'b1, 1'b0}},
    '{0, 24'd0, '{32'sd12800, 32'sd0, 32'sd0, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'sd12800, 32'sd3200, 32'sd0, 1'b0}, 1,
      '{32'sd12800, 32'sd0, 32'sd0, 1'b1, 1'b0}},
    '{0, 24'd0, '{32'sd12800, 32'sd3200, 32'sd1600, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'sd12800, 32'sd3200, -32'sd6400, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1}, 0, '0},
    '{0, 24'd0, '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'h7fffffff, 32'h80000000, 32'sd0, 1'b0}, 0, '0},
    '{0, 24'd0, '{-32'sd1, -32'sd1, -32'sd1, 1'b1}, 0, '0},
    '{0, 24'd0, '{32'sd1, 32'sd1, 32'sd1, 1'b0}, 0, '0},
    '{1, 24'd0, '{32'sd0, 32'sd0, 32'sd0, 1'b1}, 0, '0},
    '{0, 24'd0, '{32'sd81920, 32'sd0, 32'sd0, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'sd166400, 32'sd0, 32'sd0, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'sd166400, -32'sd5000, 32'sd7000, 1'b0}, 0, '0},
    '{1, 24'hffffff, '{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1}, 0, '0},
    '{0, 24'd0, '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0}, 0, '0},
    '{0, 24'd0, '{32'h55555555, 32'haaaaaaaa, 32'h0000ffff, 1'b0}, 0, '0}
  };

  initial begin
    pesr_in_t v;
    logic signed [63:0] cx, cy, cz;
    logic [23:0] chunk_spacing;
    int sp, pick;
    in_if.valid = 1'b0;
    in_if.data = '0;
    spacing_q8 = SPACING_RESET;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    carry_q8 = '0;
    have_vertex = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].write_cfg) write_spacing(rows[i].cfg_value);
      offer_vertex(rows[i].vertex, rows[i].typed, rows[i].dot);
    end

    cx = 0;
    cy = 0;
    cz = 0;
    for (int c = 0; c < CHUNKS; c++) begin
      case (c)
        0: chunk_spacing = $urandom_range(0, 1279);
        1: chunk_spacing = $urandom_range(1280, 8000);
        2: chunk_spacing = 24'hffffff;
        3: chunk_spacing = $urandom_range(1280, 30000);
        4: chunk_spacing = 24'd1280;
        default: chunk_spacing = $urandom_range(2000, 12000);
      endcase
      write_spacing(chunk_spacing);
      tx_idle_pct = c < 2 ? 9 : (c < 4 ? 81 : 0);
      rx_idle_pct = c < 2 ? 81 : (c < 4 ? 9 : 0);
      sp = spacing_q8;
      for (int i = 0; i < CHUNK_POINTS; i++) begin
        if (c == 4 && i == 10) hold_request = 1;
        pick = $urandom_range(0, 99);
        v.path_start = 1'b0;
        if (pick < 6 || pick >= 6 && pick < 10) begin
          cx = $signed($urandom());
          cy = $signed($urandom());
          cz = $signed($urandom());
          v.path_start = pick < 6;
        end else if (pick < 14) begin
        end else if (pick < 20) begin
          cx += random_step(sp / 2);
          cy += random_step(sp / 2);
          cz += random_step(sp / 2);
        end else if (pick < 25) begin
          cx += random_step(sp * 80);
          cy += random_step(sp * 80);
          cz += random_step(sp * 80);
        end else begin
          cx += random_step(sp * 3);
          cy += random_step(sp * 3);
          cz += random_step(sp * 3);
        end
        v.point_x = clamp32(cx);
        v.point_y = clamp32(cy);
        v.point_z = clamp32(cz);
        cx = $signed(v.point_x);
        cy = $signed(v.point_y);
        cz = $signed(v.point_z);
        offer_vertex(v, 0, '0);
      end
    end

    drain_dots();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
